@@ rtl/tnt_pkg.sv @@
// Shared types, constants and helper functions for the triangle normal and tangent block.
package tnt_pkg;

  // Wide operand width used by the divider and the accumulators
  localparam int unsigned WIDE_W   = 62;
  localparam int unsigned DIV_CNT_W = 7;
  localparam int unsigned SHIFT_W  = 5;

  // Fixed fractional shift of the tangent quotient (Q16.16)
  localparam logic [SHIFT_W-1:0] TAN_FRAC = SHIFT_W'(16);

  // Saturated tangent words
  localparam logic [31:0] TAN_POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] TAN_NEG_MAX = 32'h8000_0000;

  // Status bits
  localparam int unsigned STAT_NRM_ZERO = 0;
  localparam int unsigned STAT_DET_ZERO = 1;

  // Divider control word
  typedef struct packed {
    logic               start;
    logic               rnd;
    logic [SHIFT_W-1:0] k;
  } tnt_div_ctl_t;

  function automatic logic signed [32:0] sub33(input logic [31:0] a, input logic [31:0] b);
    return $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [WIDE_W-1:0] mag62(input logic signed [WIDE_W-1:0] v);
    return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
  endfunction

  // Divide by 2^s, truncating toward zero; result fits 31 bits signed
  function automatic logic signed [30:0] scale31(input logic signed [32:0] v,
                                                 input logic [1:0] s);
    logic [32:0] m;
    logic [30:0] t;
    m = mag33(v) >> s;
    t = m[30:0];
    return v[32] ? -$signed(t) : $signed(t);
  endfunction

endpackage

@@ rtl/triangle_normal_tangent.sv @@
// Top level: vertex grouping, sequencer and datapath for face normal and tangent.
// Corners 0 and 1 of a triangle are only registered and give no word. The third
// corner starts the computation: edge differences, a common prescale, cross products
// on the shared multiplier, one-bit normalising shifts, the squares and the square
// root, then up to six serial divisions; then three words are offered in turn.
// Reset (rst_ni low, asynchronous) returns to corner 0.
module triangle_normal_tangent (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               restart_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] tex_u_i,
  input  logic signed [31:0] tex_v_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic signed [31:0] tangent_x_o,
  output logic signed [31:0] tangent_y_o,
  output logic signed [31:0] tangent_z_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import tnt_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_EDGE   = 11'b000_0000_0010,
    ST_SCALE  = 11'b000_0000_0100,
    ST_MUL    = 11'b000_0000_1000,
    ST_MAG    = 11'b000_0001_0000,
    ST_NSHIFT = 11'b000_0010_0000,
    ST_SQ     = 11'b000_0100_0000,
    ST_SQRT   = 11'b000_1000_0000,
    ST_NDIV   = 11'b001_0000_0000,
    ST_TDIV   = 11'b010_0000_0000,
    ST_EMIT   = 11'b100_0000_0000
  } state_e;

  localparam logic [1:0] CORNER0 = 2'd0;
  localparam logic [1:0] CORNER1 = 2'd1;
  localparam logic [1:0] CORNER2 = 2'd2;
  localparam logic [1:0] CORNER_BAD = 2'd3;
  localparam logic [3:0] MUL_LAST = 4'd14;
  localparam logic [3:0] SQ_LAST  = 4'd3;

  state_e state_q, state_d;
  logic [1:0] phase_q, phase_d, ph;
  logic [3:0] j_q, j_d;
  logic [1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic       wait_q, wait_d;

  logic [31:0] p0_q [3], p1_q [3], p2_q [3];
  logic [31:0] t0_q [2], t1_q [2], t2_q [2];
  logic signed [32:0] er_q [6], ur_q [4];
  logic signed [30:0] e_q [6], u_q [4];
  logic [1:0]  se_q;
  logic signed [WIDE_W-1:0] res_q [7];
  logic [60:0] a_q [3];
  logic [60:0] m_q;
  logic [WIDE_W-1:0] sum_q;
  logic [30:0] len_q;
  logic [15:0] nrm_q [3];
  logic [31:0] tan_q [3];
  logic [1:0]  status_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [3:0]  jm1;
  logic [2:0]  tgt;
  logic [60:0] cm [3];
  logic [60:0] mmax;
  logic        c_zero;
  logic [32:0] eor, uor;
  logic [1:0]  se_n, su_n;
  logic        sqrt_start, sqrt_done;
  logic [30:0] root;
  tnt_div_ctl_t div_ctl;
  logic [WIDE_W-1:0] div_num, div_den;
  logic        div_done;
  logic [31:0] quo;
  logic [2:0]  nidx;
  logic        tneg;

  // shared units
  tnt_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  tnt_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .rad_i(sum_q), .done_o(sqrt_done), .root_o(root)
  );

  tnt_div u_div (
    .clk_i, .rst_ni, .ctl_i(div_ctl), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(quo)
  );

  assign ph = (restart_i || phase_q == CORNER_BAD) ? CORNER0 : phase_q;

  // cross product magnitudes and their maximum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cm[i] = mag62(res_q[i])[60:0];
    end
    mmax = cm[0];
    if (cm[1] > mmax) mmax = cm[1];
    if (cm[2] > mmax) mmax = cm[2];
    c_zero = (mmax == '0);
  end

  // common prescale shifts from the OR of the magnitudes
  always_comb begin
    eor = '0;
    uor = '0;
    for (int i = 0; i < 6; i++) eor = eor | mag33(er_q[i]);
    for (int i = 0; i < 4; i++) uor = uor | mag33(ur_q[i]);
    se_n = eor[32] ? 2'd3 : eor[31] ? 2'd2 : eor[30] ? 2'd1 : 2'd0;
    su_n = uor[32] ? 2'd3 : uor[31] ? 2'd2 : uor[30] ? 2'd1 : 2'd0;
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_MUL) begin
      case (j_q)
        4'd0:  begin mul_a = 32'(e_q[1]); mul_b = 32'(e_q[5]); end
        4'd1:  begin mul_a = 32'(e_q[2]); mul_b = 32'(e_q[4]); end
        4'd2:  begin mul_a = 32'(e_q[2]); mul_b = 32'(e_q[3]); end
        4'd3:  begin mul_a = 32'(e_q[0]); mul_b = 32'(e_q[5]); end
        4'd4:  begin mul_a = 32'(e_q[0]); mul_b = 32'(e_q[4]); end
        4'd5:  begin mul_a = 32'(e_q[1]); mul_b = 32'(e_q[3]); end
        4'd6:  begin mul_a = 32'(u_q[0]); mul_b = 32'(u_q[3]); end
        4'd7:  begin mul_a = 32'(u_q[2]); mul_b = 32'(u_q[1]); end
        4'd8:  begin mul_a = 32'(u_q[3]); mul_b = 32'(e_q[0]); end
        4'd9:  begin mul_a = 32'(u_q[1]); mul_b = 32'(e_q[3]); end
        4'd10: begin mul_a = 32'(u_q[3]); mul_b = 32'(e_q[1]); end
        4'd11: begin mul_a = 32'(u_q[1]); mul_b = 32'(e_q[4]); end
        4'd12: begin mul_a = 32'(u_q[3]); mul_b = 32'(e_q[2]); end
        4'd13: begin mul_a = 32'(u_q[1]); mul_b = 32'(e_q[5]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == ST_SQ) begin
      case (j_q)
        4'd0:    begin mul_a = {2'b0, a_q[0][29:0]}; mul_b = {2'b0, a_q[0][29:0]}; end
        4'd1:    begin mul_a = {2'b0, a_q[1][29:0]}; mul_b = {2'b0, a_q[1][29:0]}; end
        4'd2:    begin mul_a = {2'b0, a_q[2][29:0]}; mul_b = {2'b0, a_q[2][29:0]}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign jm1 = j_q - 4'd1;
  assign tgt = jm1[3:1];
  assign nidx = 3'd4 + 3'(idx_q);

  // divider operands
  always_comb begin
    if (state_q == ST_NDIV) begin
      div_num = WIDE_W'({a_q[idx_q][29:0], 14'd0}) + WIDE_W'(len_q >> 1);
      div_den = WIDE_W'(len_q);
    end else begin
      div_num = mag62(res_q[nidx]);
      div_den = mag62(res_q[3]);
    end
  end

  assign tneg = res_q[nidx][WIDE_W-1] ^ res_q[3][WIDE_W-1];

  // sequencer
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    j_d     = j_q;
    idx_d   = idx_q;
    wait_d  = wait_q;
    cnt_d   = cnt_q;
    div_ctl = '0;
    sqrt_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          if (ph == CORNER2) begin
            phase_d = CORNER0;
            state_d = ST_EDGE;
          end else begin
            phase_d = ph + 2'd1;
          end
        end
      end
      ST_EDGE: state_d = ST_SCALE;
      ST_SCALE: begin
        state_d = ST_MUL;
        j_d     = '0;
      end
      ST_MUL: begin
        j_d = j_q + 4'd1;
        if (j_q == MUL_LAST) state_d = ST_MAG;
      end
      ST_MAG: begin
        idx_d  = '0;
        wait_d = 1'b0;
        state_d = c_zero ? ST_TDIV : ST_NSHIFT;
      end
      ST_NSHIFT: begin
        if (m_q[60:30] == '0 && m_q[29]) begin
          state_d = ST_SQ;
          j_d     = '0;
        end
      end
      ST_SQ: begin
        j_d = j_q + 4'd1;
        if (j_q == SQ_LAST) begin
          state_d = ST_SQRT;
          wait_d  = 1'b0;
        end
      end
      ST_SQRT: begin
        if (!wait_q) begin
          sqrt_start = 1'b1;
          wait_d     = 1'b1;
        end else if (sqrt_done) begin
          state_d = ST_NDIV;
          wait_d  = 1'b0;
          idx_d   = '0;
        end
      end
      ST_NDIV: begin
        if (!wait_q) begin
          div_ctl.start = 1'b1;
          wait_d        = 1'b1;
        end else if (div_done) begin
          wait_d = 1'b0;
          idx_d  = idx_q + 2'd1;
          if (idx_q == 2'd2) begin
            state_d = ST_TDIV;
            idx_d   = '0;
          end
        end
      end
      ST_TDIV: begin
        if (status_q[STAT_DET_ZERO]) begin
          state_d = ST_EMIT;
          cnt_d   = '0;
        end else if (!wait_q) begin
          div_ctl.start = 1'b1;
          div_ctl.rnd   = 1'b1;
          div_ctl.k     = TAN_FRAC + SHIFT_W'(se_q);
          wait_d        = 1'b1;
        end else if (div_done) begin
          wait_d = 1'b0;
          idx_d  = idx_q + 2'd1;
          if (idx_q == 2'd2) begin
            state_d = ST_EMIT;
            cnt_d   = '0;
          end
        end
      end
      ST_EMIT: begin
        if (ready_i) begin
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd2) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= CORNER0;
      j_q     <= '0;
      idx_q   <= '0;
      wait_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      j_q     <= j_d;
      idx_q   <= idx_d;
      wait_q  <= wait_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          case (ph)
            CORNER0: begin
              p0_q[0] <= pos_x_i; p0_q[1] <= pos_y_i; p0_q[2] <= pos_z_i;
              t0_q[0] <= tex_u_i; t0_q[1] <= tex_v_i;
            end
            CORNER1: begin
              p1_q[0] <= pos_x_i; p1_q[1] <= pos_y_i; p1_q[2] <= pos_z_i;
              t1_q[0] <= tex_u_i; t1_q[1] <= tex_v_i;
            end
            default: begin
              p2_q[0] <= pos_x_i; p2_q[1] <= pos_y_i; p2_q[2] <= pos_z_i;
              t2_q[0] <= tex_u_i; t2_q[1] <= tex_v_i;
            end
          endcase
        end
      end
      ST_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          er_q[i]     <= sub33(p1_q[i], p0_q[i]);
          er_q[3 + i] <= sub33(p2_q[i], p0_q[i]);
        end
        ur_q[0] <= sub33(t1_q[0], t0_q[0]);
        ur_q[1] <= sub33(t1_q[1], t0_q[1]);
        ur_q[2] <= sub33(t2_q[0], t0_q[0]);
        ur_q[3] <= sub33(t2_q[1], t0_q[1]);
      end
      ST_SCALE: begin
        for (int i = 0; i < 6; i++) e_q[i] <= scale31(er_q[i], se_n);
        for (int i = 0; i < 4; i++) u_q[i] <= scale31(ur_q[i], su_n);
        se_q <= se_n;
      end
      ST_MUL: begin
        // even products load, odd ones subtract
        if (j_q != 4'd0) begin
          if (!jm1[0]) res_q[tgt] <= prod[WIDE_W-1:0];
          else         res_q[tgt] <= res_q[tgt] - prod[WIDE_W-1:0];
        end
      end
      ST_MAG: begin
        for (int i = 0; i < 3; i++) a_q[i] <= cm[i];
        m_q <= mmax;
        status_q[STAT_NRM_ZERO] <= c_zero;
        status_q[STAT_DET_ZERO] <= (res_q[3] == '0);
        if (c_zero) begin
          for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
        end
      end
      ST_NSHIFT: begin
        // bring the largest magnitude into [2^29, 2^30)
        if (m_q[60:30] != '0) begin
          m_q <= m_q >> 1;
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
        end else if (!m_q[29]) begin
          m_q <= m_q << 1;
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
        end
      end
      ST_SQ: begin
        if (j_q != 4'd0) begin
          sum_q <= (j_q == 4'd1 ? '0 : sum_q) + prod[WIDE_W-1:0];
        end
      end
      ST_SQRT: begin
        if (wait_q && sqrt_done) len_q <= root;
      end
      ST_NDIV: begin
        if (wait_q && div_done) begin
          nrm_q[idx_q] <= res_q[idx_q][WIDE_W-1] ? 16'(-quo[15:0]) : quo[15:0];
        end
      end
      ST_TDIV: begin
        if (status_q[STAT_DET_ZERO]) begin
          // zero determinant: saturate toward the numerator's sign; a zero numerator gives zero
          for (int i = 0; i < 3; i++) begin
            if (res_q[4 + i] == '0)             tan_q[i] <= '0;
            else if (res_q[4 + i][WIDE_W-1])    tan_q[i] <= TAN_NEG_MAX;
            else                                tan_q[i] <= TAN_POS_MAX;
          end
        end else if (wait_q && div_done) begin
          tan_q[idx_q] <= tneg ? 32'(-quo) : (quo[31] ? TAN_POS_MAX : quo);
        end
      end
      default: ;
    endcase
  end

  // output words
  assign ready_o     = (state_q == ST_IDLE);
  assign valid_o     = (state_q == ST_EMIT);
  assign last_o      = (cnt_q == 2'd2);
  assign normal_x_o  = nrm_q[0];
  assign normal_y_o  = nrm_q[1];
  assign normal_z_o  = nrm_q[2];
  assign tangent_x_o = tan_q[0];
  assign tangent_y_o = tan_q[1];
  assign tangent_z_o = tan_q[2];
  assign status_o    = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ready_o && valid_o))
    else $error("input taken while a word is offered");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid_o && ready_i && last_o |=> !valid_o && ready_o)
    else $error("no return to idle after the third word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid_i && ready_o && !restart_i && phase_q == CORNER2 |=> !ready_o)
    else $error("third corner did not start the computation");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid_o && !ready_i |=> valid_o && $stable(cnt_q))
    else $error("word count moved while stalled");

endmodule

@@ rtl/tnt_mul.sv @@
// Shared signed 32 x 32 multiplier with a registered product.
module tnt_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_q;

  // product register, no reset on payload
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ rtl/tnt_sqrt.sv @@
// Iterative floor square root, two radicand bits per cycle.
module tnt_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tnt_pkg::WIDE_W-1:0]   rad_i,
  output logic                         done_o,
  output logic [30:0]                  root_o
);
  import tnt_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] x_q, res_q, bit_q;
  logic [63:0] trial;

  assign trial = res_q + bit_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // bit-pair recurrence
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= 64'(rad_i);
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[30:0];

endmodule

@@ rtl/tnt_div.sv @@
// Restoring serial divider: one quotient bit a cycle, extra fraction bits, sticky saturation.
module tnt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tnt_pkg::tnt_div_ctl_t         ctl_i,
  input  logic [tnt_pkg::WIDE_W-1:0]    num_i,
  input  logic [tnt_pkg::WIDE_W-1:0]    den_i,
  output logic                          done_o,
  output logic [31:0]                   quo_o
);
  import tnt_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q, end_q;
  logic [WIDE_W-1:0]    n_q, d_q, r_q;
  logic [30:0]          q_q;
  logic                 sat_q, rnd_q;
  logic [WIDE_W:0]      r_sh;
  logic                 ge, up;
  logic [31:0]          q_rnd;

  // trial subtract of the shifted remainder
  assign r_sh = {r_q, n_q[WIDE_W-1]};
  assign ge   = r_sh >= {1'b0, d_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == end_q - 1'b1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      n_q   <= num_i;
      d_q   <= den_i;
      r_q   <= '0;
      q_q   <= '0;
      sat_q <= 1'b0;
      rnd_q <= ctl_i.rnd;
      end_q <= DIV_CNT_W'(WIDE_W) + DIV_CNT_W'(ctl_i.k);
    end else if (busy_q) begin
      n_q   <= n_q << 1;
      r_q   <= ge ? WIDE_W'(r_sh - {1'b0, d_q}) : r_sh[WIDE_W-1:0];
      q_q   <= {q_q[29:0], ge};
      sat_q <= sat_q | q_q[30];
    end
  end

  // round half up, then clamp to 2^31
  assign up    = rnd_q && ({r_q, 1'b0} >= {1'b0, d_q});
  assign q_rnd = {1'b0, q_q} + 32'(up);
  assign quo_o = sat_q ? TAN_NEG_MAX : q_rnd;
  assign done_o = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) ctl_i.start |-> den_i != '0)
    else $error("divider started with zero divisor");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctl_i.start |-> !busy_q)
    else $error("divider restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> r_q < d_q)
    else $error("divider remainder not below divisor");

endmodule
